### hdl/crcf_pkg.sv
// Shared types and constants for the CRC-16 frame receiver.
package crcf_pkg;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [7:0]  START_MARKER_RESET  = 8'd170;
   localparam logic [15:0] CRC_SEED_RESET      = 16'hFFFF;
   localparam logic [15:0] PAYLOAD_LIMIT_RESET = 16'd256;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_MARKER  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CRC_SEED      = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAYLOAD_LIMIT = 2'd2;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_EOF  = 1'b1;

   localparam logic [1:0] STATUS_GOOD    = 2'd0;
   localparam logic [1:0] STATUS_CRC_BAD = 2'd1;
   localparam logic [1:0] STATUS_LEN_ERR = 2'd2;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_TYPE    = 3'd1,
      PH_LEN_HI  = 3'd2,
      PH_LEN_LO  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CRC_HI  = 3'd5,
      PH_CRC_LO  = 3'd6
   } phase_type;

   typedef struct packed {
      logic [7:0]  start_marker;
      logic [15:0] crc_seed;
      logic [15:0] payload_limit;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic        kind;
      logic [7:0]  data_byte;
      logic [7:0]  message_type;
      logic [15:0] frame_length;
      logic [1:0]  status;
   } result_type;

endpackage

### hdl/crcf_crc_byte.sv
// CRC-16 update over one byte, polynomial 0x1021, MSB first.
module crcf_crc_byte
   import crcf_pkg::*;
(
   input  logic [15:0] acc,
   input  logic [7:0]  data,
   output logic [15:0] crc_next
);

   always_comb begin
      logic [15:0] c;
      c = acc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      crc_next = c;
   end

endmodule

### hdl/crcf_parser.sv
// Frame parsing state machine with header fields and running CRC.
module crcf_parser
   import crcf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  held_type_ff, held_type_in;
   logic [15:0] held_length_ff, held_length_in;
   logic [15:0] bytes_seen_ff, bytes_seen_in;
   logic [15:0] crc_acc_ff, crc_acc_in;
   logic [7:0]  crc_high_ff, crc_high_in;

   logic [15:0] crc_base;
   logic [15:0] crc_upd;
   logic [15:0] length_full;
   logic [15:0] seen_inc;

   // Seed is loaded only on the start marker
   assign crc_base = (phase_ff == PH_TYPE || phase_ff == PH_LEN_HI || phase_ff == PH_LEN_LO ||
                      phase_ff == PH_PAYLOAD) ? crc_acc_ff : cfg.crc_seed;

   crcf_crc_byte u_crc (
      .acc      (crc_base),
      .data     (rx_byte),
      .crc_next (crc_upd)
   );

   assign length_full = {held_length_ff[15:8], rx_byte};
   assign seen_inc    = bytes_seen_ff + 16'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         held_type_ff   <= '0;
         held_length_ff <= '0;
         bytes_seen_ff  <= '0;
         crc_acc_ff     <= '0;
         crc_high_ff    <= '0;
      end else if (fire) begin
         phase_ff       <= phase_in;
         held_type_ff   <= held_type_in;
         held_length_ff <= held_length_in;
         bytes_seen_ff  <= bytes_seen_in;
         crc_acc_ff     <= crc_acc_in;
         crc_high_ff    <= crc_high_in;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      held_type_in   = held_type_ff;
      held_length_in = held_length_ff;
      bytes_seen_in  = bytes_seen_ff;
      crc_acc_in     = crc_acc_ff;
      crc_high_in    = crc_high_ff;
      result.valid        = 1'b0;
      result.kind         = KIND_DATA;
      result.data_byte    = '0;
      result.message_type = held_type_ff;
      result.frame_length = held_length_ff;
      result.status       = STATUS_GOOD;
      case (phase_ff)
         PH_TYPE: begin
            held_type_in = rx_byte;
            crc_acc_in   = crc_upd;
            phase_in     = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            held_length_in = {rx_byte, 8'h00};
            crc_acc_in     = crc_upd;
            phase_in       = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            held_length_in = length_full;
            crc_acc_in     = crc_upd;
            bytes_seen_in  = '0;
            if (length_full > cfg.payload_limit) begin
               phase_in            = PH_HUNT;
               result.valid        = 1'b1;
               result.kind         = KIND_EOF;
               result.frame_length = length_full;
               result.status       = STATUS_LEN_ERR;
            end else if (length_full == 16'd0) begin
               phase_in = PH_CRC_HI;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            crc_acc_in    = crc_upd;
            bytes_seen_in = seen_inc;
            if (seen_inc >= held_length_ff) begin
               phase_in = PH_CRC_HI;
            end
            result.valid     = 1'b1;
            result.kind      = KIND_DATA;
            result.data_byte = rx_byte;
         end
         PH_CRC_HI: begin
            crc_high_in = rx_byte;
            phase_in    = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            phase_in      = PH_HUNT;
            result.valid  = 1'b1;
            result.kind   = KIND_EOF;
            result.status = ({crc_high_ff, rx_byte} == crc_acc_ff) ? STATUS_GOOD
                                                                   : STATUS_CRC_BAD;
         end
         default: begin
            // Hunting; an unused phase code falls here too
            phase_in = PH_HUNT;
            if (rx_byte == cfg.start_marker) begin
               crc_acc_in = crc_upd;
               phase_in   = PH_TYPE;
            end
         end
      endcase
   end

endmodule

### hdl/crc16_frame_receiver_unit.sv
// Top level of the CRC-16 frame receiver: input register, parser, result register.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_rx_byte
//  rsp     | out       | rsp_valid/rsp_stall | rsp_kind, rsp_data_byte, rsp_message_type,
//          |           |                     | rsp_frame_length, rsp_status
//  csr     | in        | csr_write_enable    | csr_index, csr_wdata
//
// One byte per cycle sustained while rsp is not stalled; results are registered.
// The input register and the result register each hold one transaction, so a byte is
// taken while a result still waits. Stall on rsp with a result waiting holds the result
// register and the parser; req_stall rises only once the input register is also full.
// Synchronous reset returns to hunting and loads the register defaults.
module crc16_frame_receiver_unit
   import crcf_pkg::*;
#(
   parameter int CsrIndexWidth = CSR_INDEX_WIDTH,
   parameter int CsrDataWidth  = CSR_DATA_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_rx_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_kind,
   output logic [7:0]               rsp_data_byte,
   output logic [7:0]               rsp_message_type,
   output logic [15:0]              rsp_frame_length,
   output logic [1:0]               rsp_status,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   result_type res_ff;
   result_type res_comb;
   logic       advance;
   logic       fire;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker  <= START_MARKER_RESET;
         cfg_ff.crc_seed      <= CRC_SEED_RESET;
         cfg_ff.payload_limit <= PAYLOAD_LIMIT_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CsrIndexWidth'(CSR_START_MARKER)) begin
            cfg_ff.start_marker <= csr_wdata[7:0];
         end
         if (csr_index == CsrIndexWidth'(CSR_CRC_SEED)) begin
            cfg_ff.crc_seed <= csr_wdata[15:0];
         end
         if (csr_index == CsrIndexWidth'(CSR_PAYLOAD_LIMIT)) begin
            cfg_ff.payload_limit <= csr_wdata[15:0];
         end
      end
   end

   // Result register is free when empty or being drained this cycle
   assign advance   = !res_ff.valid || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   crcf_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .result  (res_comb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else if (advance) begin
         res_ff.valid <= fire && res_comb.valid;
      end
      if (fire && res_comb.valid) begin
         res_ff.kind         <= res_comb.kind;
         res_ff.data_byte    <= res_comb.data_byte;
         res_ff.message_type <= res_comb.message_type;
         res_ff.frame_length <= res_comb.frame_length;
         res_ff.status       <= res_comb.status;
      end
   end

   assign rsp_valid        = res_ff.valid;
   assign rsp_kind         = res_ff.kind;
   assign rsp_data_byte    = res_ff.data_byte;
   assign rsp_message_type = res_ff.message_type;
   assign rsp_frame_length = res_ff.frame_length;
   assign rsp_status       = res_ff.status;

endmodule

### hdl/crcf_checker.sv
// Port-level checks for the CRC-16 frame receiver, bound to the top level.
module crcf_checker
   import crcf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_kind,
   input logic [7:0]  rsp_data_byte,
   input logic [1:0]  rsp_status
);

   // Hold a stalled transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_data_byte) && $stable(rsp_status))
      else $error("stalled result changed");

   a_data_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DATA |-> rsp_status == STATUS_GOOD)
      else $error("payload byte carries a status");

   a_eof_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_EOF |-> rsp_data_byte == 8'h00)
      else $error("end-of-frame result carries data");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_GOOD || rsp_status == STATUS_CRC_BAD ||
      rsp_status == STATUS_LEN_ERR)
      else $error("unknown status code");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind crc16_frame_receiver_unit crcf_checker u_crcf_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_kind      (rsp_kind),
   .rsp_data_byte (rsp_data_byte),
   .rsp_status    (rsp_status)
);
